@@ hdl/adti_pkg.sv @@
// ----------------------------------------------------------------------------
// adti_pkg: shared types and constants for the ASCII decimal to int32 parser
// Character codes, token classes, parse phases, limits and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package adti_pkg;

  // Character codes
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // Magnitude limits
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] MAG_SAT   = 32'hFFFF_FFFF;

  // Token queue between classifier and accumulator
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QIDX_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Character class as seen by the accumulator
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_PLUS  = 3'd2,
    CLS_MINUS = 3'd3,
    CLS_DIGIT = 3'd4,
    CLS_OTHER = 3'd5
  } chr_cls_t;

  // Classified item
  typedef struct packed {
    chr_cls_t   cls;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  // Head of the token queue
  typedef struct packed {
    logic valid;
    tok_t tok;
  } qhead_t;

  // Parse phase
  typedef enum logic [2:0] {
    PH_LEAD = 3'b001,
    PH_NUM  = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

endpackage

`default_nettype wire

@@ hdl/adti_if.sv @@
// ----------------------------------------------------------------------------
// adti_if: channel interfaces of the parser
// Character input channel and integer result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface adti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       char_valid;
  logic       last_char;

  modport source (output valid, output character, output char_valid,
                  output last_char, input ready);
  modport sink   (input valid, input character, input char_valid,
                  input last_char, output ready);
endinterface

interface adti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               clamped;

  modport source (output valid, output value, output clamped, input ready);
  modport sink   (input valid, input value, input clamped, output ready);
endinterface

`default_nettype wire

@@ hdl/ascii_decimal_to_int32_saturating.sv @@
// ----------------------------------------------------------------------------
// ascii_decimal_to_int32_saturating: streaming ASCII decimal to int32 parser
// Skips leading spaces, takes one sign, accumulates digits with saturation
// and gives a clamped signed 32-bit value at the end of each string.
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload                           | transfer
//   ---------+-----------+-----------------------------------+-------------------
//   in_ch    | in        | character, char_valid, last_char  | valid && ready
//   out_ch   | out       | value, clamped                    | valid && ready
//
// One character per cycle while the token queue has room; the rate is set by the
// combinational multiply-by-ten-and-add step in the accumulator.
// The last character is first written into the queue, then popped into the result
// register, which offers the result on out_ch.
// Synchronous active-low reset clears phase, sign, magnitude and the queue.
// A stalled result holds the accumulator only when the next token is a last
// token; the two-entry queue keeps accepting characters until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_decimal_to_int32_saturating
  import adti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  adti_in_if.sink     in_ch,
  adti_out_if.source  out_ch
);

  logic   q_ready;
  logic   push;
  tok_t   push_tok;
  logic   pop;
  qhead_t head;

  // Classifier
  adti_front u_front (
    .in_ch    (in_ch),
    .q_ready  (q_ready),
    .push     (push),
    .push_tok (push_tok)
  );

  // Token queue
  adti_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .q_ready  (q_ready),
    .pop      (pop),
    .head     (head)
  );

  // Accumulator and result register
  adti_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  // Queue is never popped while empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty token queue");

  // A finished string never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.tok.last |-> !out_ch.valid || out_ch.ready)
    else $error("result overwritten while stalled");

  // A clamped result sits at one of the int32 limits
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clamped |->
      out_ch.value == POS_LIMIT || out_ch.value == NEG_LIMIT)
    else $error("clamped value off the int32 limits");
`endif

endmodule

`default_nettype wire

@@ hdl/adti_front.sv @@
// ----------------------------------------------------------------------------
// adti_front: character classifier
// Takes input transfers and turns each character into a token for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module adti_front
  import adti_pkg::*;
(
  adti_in_if.sink in_ch,
  input  logic    q_ready,
  output logic    push,
  output tok_t    push_tok
);

  logic [7:0] ofs;

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;

  // Offset from '0'; a digit when it lands in 0..9
  assign ofs = in_ch.character - CHR_ZERO;

  always_comb begin
    push_tok.digit = ofs[3:0];
    push_tok.last  = in_ch.last_char;
    if (!in_ch.char_valid) begin
      push_tok.cls = CLS_NONE;
    end else if (in_ch.character == CHR_SPACE) begin
      push_tok.cls = CLS_SPACE;
    end else if (in_ch.character == CHR_PLUS) begin
      push_tok.cls = CLS_PLUS;
    end else if (in_ch.character == CHR_MINUS) begin
      push_tok.cls = CLS_MINUS;
    end else if (in_ch.character >= CHR_ZERO && ofs <= {4'd0, DIGIT_MAX}) begin
      push_tok.cls = CLS_DIGIT;
    end else begin
      push_tok.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

@@ hdl/adti_queue.sv @@
// ----------------------------------------------------------------------------
// adti_queue: token queue
// Two-entry FIFO between classifier and accumulator; head shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module adti_queue
  import adti_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  tok_t   push_tok,
  output logic   q_ready,
  input  logic   pop,
  output qhead_t head
);

  tok_t              ent_r [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_ready    = cnt_r != QCNT_W'(QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.tok   = ent_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

@@ hdl/adti_back.sv @@
// ----------------------------------------------------------------------------
// adti_back: phase tracker, digit accumulator and result register
// Pops tokens, builds the saturating magnitude, clamps it on the last token.
// ----------------------------------------------------------------------------
`default_nettype none

module adti_back
  import adti_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qhead_t    head,
  output logic      pop,
  adti_out_if.source out_ch
);

  phase_t      ph_r, ph_nxt, ph_step;
  logic        neg_r, neg_nxt, neg_step;
  logic [31:0] mag_r, mag_nxt, mag_step;
  logic [35:0] prod;
  logic [31:0] mag_add;

  logic        out_valid_r, out_valid_nxt;
  logic        out_neg_r;
  logic [31:0] out_mag_r;

  // Pop unless a finished result would be overwritten
  assign pop = head.valid && (!head.tok.last || !out_valid_r || out_ch.ready);

  // mag * 10 + digit, saturating at all ones
  assign prod    = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + {32'd0, head.tok.digit};
  assign mag_add = (prod[35:32] != 4'd0) ? MAG_SAT : prod[31:0];

  // One token step
  always_comb begin
    ph_step  = ph_r;
    neg_step = neg_r;
    mag_step = mag_r;
    unique case (ph_r)
      PH_LEAD: begin
        case (head.tok.cls) inside
          CLS_NONE, CLS_SPACE: ;
          CLS_PLUS: ph_step = PH_NUM;
          CLS_MINUS: begin
            neg_step = 1'b1;
            ph_step  = PH_NUM;
          end
          CLS_DIGIT: begin
            mag_step = mag_add;
            ph_step  = PH_NUM;
          end
          default: ph_step = PH_STOP;
        endcase
      end
      PH_NUM: begin
        if (head.tok.cls == CLS_DIGIT) begin
          mag_step = mag_add;
        end else if (head.tok.cls != CLS_NONE) begin
          ph_step = PH_STOP;
        end
      end
      PH_STOP: ;
      default: ;
    endcase
  end

  // State update; the last token hands off and restarts
  always_comb begin
    ph_nxt        = ph_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop) begin
      if (head.tok.last) begin
        ph_nxt        = PH_LEAD;
        neg_nxt       = 1'b0;
        mag_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        ph_nxt  = ph_step;
        neg_nxt = neg_step;
        mag_nxt = mag_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_LEAD;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (pop && head.tok.last) begin
      out_neg_r <= neg_step;
      out_mag_r <= mag_step;
    end
  end

  // Clamp to the int32 range for the sign
  always_comb begin
    out_ch.valid = out_valid_r;
    if (out_neg_r) begin
      out_ch.clamped = out_mag_r > NEG_LIMIT;
      out_ch.value   = out_ch.clamped ? NEG_LIMIT : 32'd0 - out_mag_r;
    end else begin
      out_ch.clamped = out_mag_r > POS_LIMIT;
      out_ch.value   = out_ch.clamped ? POS_LIMIT : out_mag_r;
    end
  end

endmodule

`default_nettype wire
